@@ rtl/sm_alu_pkg.sv @@
// Shared types and constants for the stack machine integer ALU core.
`timescale 1ns / 1ps
package sm_alu_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int DATA_W      = 32;
  localparam int ENTRY_W     = DATA_W + 1;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int AW          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DIV_STEPS   = DATA_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    OP_SKIP  = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIV   = 3'd4,
    OP_PUSHI = 3'd5,
    OP_PUSHS = 3'd6,
    OP_EXIT  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic push;
    logic rd_issue;
    logic commit;
    logic div_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic sp_lt2;
    logic top_is_str;
    logic below_is_str;
    logic top_zero;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

@@ rtl/sm_alu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sm_alu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/sm_alu_div.sv @@
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
`timescale 1ns / 1ps
module sm_alu_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [sm_alu_pkg::DATA_W-1:0]      dividend,
  input  logic [sm_alu_pkg::DATA_W-1:0]      divisor,
  output logic                               done,
  output logic [sm_alu_pkg::DATA_W-1:0]      quotient
);

  localparam int W = sm_alu_pkg::DATA_W;

  logic                               busy_r, busy_nxt;
  logic                               done_r, done_nxt;
  logic [sm_alu_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [W-1:0]                       rem_r, rem_nxt;
  logic [W-1:0]                       quo_r, quo_nxt;
  logic [W-1:0]                       dvs_r, dvs_nxt;
  logic                               neg_r, neg_nxt;
  logic [W:0]                         shifted;
  logic [W:0]                         diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    shifted  = {rem_r, quo_r[W-1]};
    diff     = shifted - {1'b0, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend[W-1] ? (~dividend + W'(1)) : dividend;
      dvs_nxt  = divisor[W-1] ? (~divisor + W'(1)) : divisor;
      neg_nxt  = dividend[W-1] ^ divisor[W-1];
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + sm_alu_pkg::DIV_CNT_W'(1);
      if (cnt_r == sm_alu_pkg::DIV_CNT_W'(sm_alu_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + W'(1)) : quo_r;

endmodule

@@ rtl/sm_alu_datapath.sv @@
// Datapath: top-of-stack registers, stack RAM, ALU, divider, flags, output word.
`timescale 1ns / 1ps
module sm_alu_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sm_alu_pkg::cmd_t                 cmd,
  output sm_alu_pkg::status_t              status,
  input  logic [2:0]                       in_op,
  input  logic signed [31:0]               in_imm,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic signed [31:0]               out_top_value,
  output logic                             out_top_is_string,
  output logic                             out_stack_empty,
  output logic                             out_overflow_seen,
  output logic                             out_div_zero_seen
);

  localparam int W  = sm_alu_pkg::DATA_W;
  localparam int SW = sm_alu_pkg::SP_W;

  sm_alu_pkg::op_t  op_r, op_nxt;
  logic [W-1:0]     imm_r, imm_nxt;
  logic [W-1:0]     top_val_r, top_val_nxt;
  logic             top_tag_r, top_tag_nxt;
  logic [SW-1:0]    sp_r, sp_nxt;
  logic             ovf_r, ovf_nxt;
  logic             dz_r, dz_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [W-1:0]     out_val_r, out_val_nxt;
  logic             out_tag_r, out_tag_nxt;
  logic             out_empty_r, out_empty_nxt;
  logic             out_ovf_r, out_ovf_nxt;
  logic             out_dz_r, out_dz_nxt;

  logic [SW-1:0]    sp_m1;
  logic [SW-1:0]    sp_m2;
  logic             ram_we;
  logic [sm_alu_pkg::ENTRY_W-1:0] ram_rdata;
  logic [W-1:0]     below_val;
  logic             below_tag;
  logic [W-1:0]     div_q;
  logic             div_done;
  logic [W-1:0]     alu_res;
  logic             sp_empty;
  logic             sp_full;

  assign sp_m1     = sp_r - SW'(1);
  assign sp_m2     = sp_r - SW'(2);
  assign sp_empty  = (sp_r == '0);
  assign sp_full   = (sp_r == SW'(sm_alu_pkg::STACK_DEPTH));
  assign below_val = ram_rdata[W-1:0];
  assign below_tag = ram_rdata[W];
  assign ram_we    = cmd.push && !sp_full && !sp_empty;

  sm_alu_ram #(
    .WIDTH (sm_alu_pkg::ENTRY_W),
    .DEPTH (sm_alu_pkg::STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sp_m1[sm_alu_pkg::AW-1:0]),
    .wdata ({top_tag_r, top_val_r}),
    .re    (cmd.rd_issue),
    .raddr (sp_m2[sm_alu_pkg::AW-1:0]),
    .rdata (ram_rdata)
  );

  sm_alu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (below_val),
    .divisor  (top_val_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    case (op_r)
      sm_alu_pkg::OP_ADD: alu_res = below_val + top_val_r;
      sm_alu_pkg::OP_SUB: alu_res = below_val - top_val_r;
      sm_alu_pkg::OP_MUL: alu_res = below_val * top_val_r;
      sm_alu_pkg::OP_DIV: alu_res = (top_val_r == '0) ? '0 : div_q;
      default:            alu_res = top_val_r;
    endcase
  end

  always_comb begin
    op_nxt        = op_r;
    imm_nxt       = imm_r;
    top_val_nxt   = top_val_r;
    top_tag_nxt   = top_tag_r;
    sp_nxt        = sp_r;
    ovf_nxt       = ovf_r;
    dz_nxt        = dz_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_val_nxt   = out_val_r;
    out_tag_nxt   = out_tag_r;
    out_empty_nxt = out_empty_r;
    out_ovf_nxt   = out_ovf_r;
    out_dz_nxt    = out_dz_r;

    if (cmd.latch_in) begin
      op_nxt  = sm_alu_pkg::op_t'(in_op);
      imm_nxt = in_imm;
    end

    if (cmd.push) begin
      if (sp_full) begin
        ovf_nxt = 1'b1;
      end else begin
        top_val_nxt = imm_r;
        top_tag_nxt = (op_r == sm_alu_pkg::OP_PUSHS);
        sp_nxt      = sp_r + SW'(1);
      end
    end

    if (cmd.commit) begin
      top_val_nxt = alu_res;
      top_tag_nxt = 1'b0;
      sp_nxt      = sp_m1;
      if (op_r == sm_alu_pkg::OP_DIV && top_val_r == '0) begin
        dz_nxt = 1'b1;
      end
    end

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_val_nxt   = sp_empty ? '0 : top_val_r;
      out_tag_nxt   = sp_empty ? 1'b0 : top_tag_r;
      out_empty_nxt = sp_empty;
      out_ovf_nxt   = ovf_r;
      out_dz_nxt    = dz_r;
      ovf_nxt       = 1'b0;
      dz_nxt        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      ovf_r       <= 1'b0;
      dz_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sp_r        <= sp_nxt;
      ovf_r       <= ovf_nxt;
      dz_r        <= dz_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    imm_r       <= imm_nxt;
    top_val_r   <= top_val_nxt;
    top_tag_r   <= top_tag_nxt;
    out_val_r   <= out_val_nxt;
    out_tag_r   <= out_tag_nxt;
    out_empty_r <= out_empty_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_dz_r    <= out_dz_nxt;
  end

  always_comb begin
    status.op           = op_r;
    status.sp_lt2       = (sp_r < SW'(2));
    status.top_is_str   = top_tag_r;
    status.below_is_str = below_tag;
    status.top_zero     = (top_val_r == '0);
    status.div_done     = div_done;
    status.out_free     = !out_valid_r || !out_stall;
  end

  assign out_valid         = out_valid_r;
  assign out_top_value     = out_val_r;
  assign out_top_is_string = out_tag_r;
  assign out_stack_empty   = out_empty_r;
  assign out_overflow_seen = out_ovf_r;
  assign out_div_zero_seen = out_dz_r;

endmodule

@@ rtl/sm_alu_ctrl.sv @@
// Controller state machine: sequences fetch, decode, operand read and divide.
`timescale 1ns / 1ps
module sm_alu_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sm_alu_pkg::status_t status,
  output sm_alu_pkg::cmd_t    cmd
);

  sm_alu_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sm_alu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      sm_alu_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = sm_alu_pkg::ST_DECODE;
        end
      end
      sm_alu_pkg::ST_DECODE: begin
        unique case (status.op) inside
          sm_alu_pkg::OP_SKIP: begin
            state_nxt = sm_alu_pkg::ST_IDLE;
          end
          sm_alu_pkg::OP_PUSHI, sm_alu_pkg::OP_PUSHS: begin
            cmd.push  = 1'b1;
            state_nxt = sm_alu_pkg::ST_IDLE;
          end
          sm_alu_pkg::OP_EXIT: begin
            if (status.out_free) begin
              cmd.out_load = 1'b1;
              state_nxt    = sm_alu_pkg::ST_IDLE;
            end
          end
          default: begin
            if (status.sp_lt2 || status.top_is_str) begin
              state_nxt = sm_alu_pkg::ST_IDLE;
            end else begin
              cmd.rd_issue = 1'b1;
              state_nxt    = sm_alu_pkg::ST_READ;
            end
          end
        endcase
      end
      sm_alu_pkg::ST_READ: begin
        if (status.below_is_str) begin
          state_nxt = sm_alu_pkg::ST_IDLE;
        end else if (status.op == sm_alu_pkg::OP_DIV && !status.top_zero) begin
          cmd.div_start = 1'b1;
          state_nxt     = sm_alu_pkg::ST_DIV;
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = sm_alu_pkg::ST_IDLE;
        end
      end
      sm_alu_pkg::ST_DIV: begin
        if (status.div_done) begin
          cmd.commit = 1'b1;
          state_nxt  = sm_alu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sm_alu_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/stack_machine_int_alu_core.sv @@
// Top level of the stack machine integer ALU core.
// Runs one bytecode word per input handshake on a 256-entry tagged stack. The
// top entry lives in registers; the entries below it sit in a single-port-read
// RAM. An input word is taken while idle and decoded in the cycle after; skip
// and push end at decode, and exit waits there while an earlier result word
// is still held on the output. Add, sub and mul go on to a read state for the
// RAM read of the second operand. Div then runs the iterative divider, which
// produces one quotient bit per cycle; a zero divisor skips the divider and
// commits from the read state. Arithmetic that finds fewer than two entries or
// a string on top ends at decode, and a string below ends in the read state.
// No clearing pass is needed after reset.
`timescale 1ns / 1ps
module stack_machine_int_alu_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_op,
  input  logic signed [31:0] in_imm,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_top_value,
  output logic               out_top_is_string,
  output logic               out_stack_empty,
  output logic               out_overflow_seen,
  output logic               out_div_zero_seen
);

  sm_alu_pkg::cmd_t    cmd;
  sm_alu_pkg::status_t status;

  sm_alu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sm_alu_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_op             (in_op),
    .in_imm            (in_imm),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_top_value     (out_top_value),
    .out_top_is_string (out_top_is_string),
    .out_stack_empty   (out_stack_empty),
    .out_overflow_seen (out_overflow_seen),
    .out_div_zero_seen (out_div_zero_seen)
  );

endmodule

@@ rtl/sm_alu_checker.sv @@
// Port-level checker for the stack machine integer ALU core, with its bind.
`timescale 1ns / 1ps
module sm_alu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_top_value,
  input logic               out_top_is_string,
  input logic               out_stack_empty
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_top_value))
    else $error("stalled result word changed");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stack_empty |-> out_top_value == 0 && !out_top_is_string)
    else $error("empty stack reported a nonzero top");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input word taken while previous word still decoding");

  a_result_from_decode: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word appeared without a decoded input word");

endmodule

bind stack_machine_int_alu_core sm_alu_checker u_sm_alu_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_top_value     (out_top_value),
  .out_top_is_string (out_top_is_string),
  .out_stack_empty   (out_stack_empty)
);

@@ dv/stack_machine_int_alu_core_test.sv @@
// Self-checking testbench for the stack machine integer ALU core.
`timescale 1ns / 1ps
module stack_machine_int_alu_core_test;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 48;
  localparam int RANDOM_WORDS   = 1300;

  typedef struct packed {
    logic [31:0] top_value;
    logic        top_is_string;
    logic        stack_empty;
    logic        overflow_seen;
    logic        div_zero_seen;
  } exit_word_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_op;
  logic signed [31:0] in_imm;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_top_value;
  logic               out_top_is_string;
  logic               out_stack_empty;
  logic               out_overflow_seen;
  logic               out_div_zero_seen;

  stack_machine_int_alu_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_imm            (in_imm),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_top_value     (out_top_value),
    .out_top_is_string (out_top_is_string),
    .out_stack_empty   (out_stack_empty),
    .out_overflow_seen (out_overflow_seen),
    .out_div_zero_seen (out_div_zero_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // stack shadow
  logic [31:0] stk_val [sm_alu_pkg::STACK_DEPTH];
  logic        stk_tag [sm_alu_pkg::STACK_DEPTH];
  int          depth;
  logic        ovf_pending;
  logic        dz_pending;
  exit_word_t  exits_due[$];

  int errors;
  int burst_left;
  int long_hold;
  int pat_left;
  int pat_mode;
  int idle_cycles;

  function automatic void step_stack(input sm_alu_pkg::op_t op, input logic [31:0] imm);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] r;
    exit_word_t  w;
    case (op) inside
      sm_alu_pkg::OP_ADD, sm_alu_pkg::OP_SUB, sm_alu_pkg::OP_MUL, sm_alu_pkg::OP_DIV: begin
        if (depth >= 2 && !stk_tag[depth-2] && !stk_tag[depth-1]) begin
          a = stk_val[depth-2];
          b = stk_val[depth-1];
          case (op)
            sm_alu_pkg::OP_ADD: r = a + b;
            sm_alu_pkg::OP_SUB: r = a - b;
            sm_alu_pkg::OP_MUL: r = a * b;
            default: begin
              if (b == '0) begin
                r = '0;
                dz_pending = 1'b1;
              end else begin
                r = 32'(longint'($signed(a)) / longint'($signed(b)));
              end
            end
          endcase
          stk_val[depth-2] = r;
          stk_tag[depth-2] = 1'b0;
          depth--;
        end
      end
      sm_alu_pkg::OP_PUSHI, sm_alu_pkg::OP_PUSHS: begin
        if (depth >= sm_alu_pkg::STACK_DEPTH) begin
          ovf_pending = 1'b1;
        end else begin
          stk_val[depth] = imm;
          stk_tag[depth] = (op == sm_alu_pkg::OP_PUSHS);
          depth++;
        end
      end
      sm_alu_pkg::OP_EXIT: begin
        if (depth == 0) begin
          w.top_value     = '0;
          w.top_is_string = 1'b0;
          w.stack_empty   = 1'b1;
        end else begin
          w.top_value     = stk_val[depth-1];
          w.top_is_string = stk_tag[depth-1];
          w.stack_empty   = 1'b0;
        end
        w.overflow_seen = ovf_pending;
        w.div_zero_seen = dz_pending;
        exits_due.push_back(w);
        ovf_pending = 1'b0;
        dz_pending  = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] rand_imm();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return 32'hffff_ffff;
      4: return 32'($urandom_range(0, 32)) - 32'd16;
      default: return $urandom;
    endcase
  endfunction

  function automatic sm_alu_pkg::op_t pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return sm_alu_pkg::OP_SKIP;
    if (r < 17) return sm_alu_pkg::OP_ADD;
    if (r < 29) return sm_alu_pkg::OP_SUB;
    if (r < 41) return sm_alu_pkg::OP_MUL;
    if (r < 51) return sm_alu_pkg::OP_DIV;
    // string entries never leave the stack, so keep them rare
    if (r < 55) return (depth < 180) ? sm_alu_pkg::OP_PUSHS : sm_alu_pkg::OP_PUSHI;
    if (r < 85) return sm_alu_pkg::OP_PUSHI;
    return sm_alu_pkg::OP_EXIT;
  endfunction

  task automatic send_word(input sm_alu_pkg::op_t op, input logic [31:0] imm);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_op    <= op;
    in_imm   <= imm;
    do @(posedge clk); while (in_stall);
    step_stack(op, imm);
  endtask

  task automatic test_directed_cases();
    send_word(sm_alu_pkg::OP_EXIT,  32'hffff_ffff);   // empty stack
    send_word(sm_alu_pkg::OP_ADD,   32'h0000_0000);   // nothing to add
    send_word(sm_alu_pkg::OP_PUSHI, 32'h7fff_ffff);
    send_word(sm_alu_pkg::OP_SUB,   32'hffff_ffff);   // single entry
    send_word(sm_alu_pkg::OP_EXIT,  32'h0000_0000);
    send_word(sm_alu_pkg::OP_PUSHI, 32'h0000_0001);
    send_word(sm_alu_pkg::OP_ADD,   32'h0000_0000);   // wraps to min int
    send_word(sm_alu_pkg::OP_PUSHI, 32'h8000_0000);
    send_word(sm_alu_pkg::OP_PUSHI, 32'hffff_ffff);
    send_word(sm_alu_pkg::OP_DIV,   32'h0000_0000);   // min int / -1
    send_word(sm_alu_pkg::OP_PUSHI, 32'h0000_0000);
    send_word(sm_alu_pkg::OP_DIV,   32'h0000_0000);   // divide by zero
    send_word(sm_alu_pkg::OP_EXIT,  32'h0000_0000);
    send_word(sm_alu_pkg::OP_EXIT,  32'h0000_0000);   // flags cleared
    send_word(sm_alu_pkg::OP_PUSHI, 32'hffff_fff9);
    send_word(sm_alu_pkg::OP_PUSHI, 32'h0000_0002);
    send_word(sm_alu_pkg::OP_DIV,   32'h0000_0000);   // truncates toward zero
    send_word(sm_alu_pkg::OP_MUL,   32'h0000_0000);
    send_word(sm_alu_pkg::OP_PUSHS, 32'ha5a5_a5a5);
    send_word(sm_alu_pkg::OP_MUL,   32'h0000_0000);   // mixed tags
    send_word(sm_alu_pkg::OP_PUSHS, 32'h5a5a_5a5a);
    send_word(sm_alu_pkg::OP_SUB,   32'h0000_0000);   // both strings
    send_word(sm_alu_pkg::OP_SKIP,  32'hffff_ffff);
    send_word(sm_alu_pkg::OP_EXIT,  32'h0000_0000);
  endtask

  task automatic test_full_stack();
    sm_alu_pkg::op_t op;
    while (depth < sm_alu_pkg::STACK_DEPTH) send_word(sm_alu_pkg::OP_PUSHI, rand_imm());
    send_word(sm_alu_pkg::OP_PUSHI, rand_imm());
    send_word(sm_alu_pkg::OP_PUSHS, rand_imm());
    send_word(sm_alu_pkg::OP_EXIT,  rand_imm());
    send_word(sm_alu_pkg::OP_EXIT,  rand_imm());
    // fold the stack back down to the first string entry
    while (depth >= 2 && !stk_tag[depth-1] && !stk_tag[depth-2]) begin
      case ($urandom_range(0, 7))
        0:       op = sm_alu_pkg::OP_DIV;
        1, 2:    op = sm_alu_pkg::OP_SUB;
        3, 4:    op = sm_alu_pkg::OP_MUL;
        default: op = sm_alu_pkg::OP_ADD;
      endcase
      send_word(op, rand_imm());
    end
    send_word(sm_alu_pkg::OP_EXIT, rand_imm());
  endtask

  task automatic test_backpressure();
    long_hold = LONG_HOLD;
    repeat (40)
      send_word(($urandom_range(0, 3) == 0) ? sm_alu_pkg::OP_EXIT : pick_op(),
                rand_imm());
  endtask

  task automatic test_random_programs();
    repeat (RANDOM_WORDS) send_word(pick_op(), rand_imm());
  endtask

  // result receiver: long hold on request, otherwise a changing stall pattern
  always @(posedge clk) begin
    if (long_hold > 0) begin
      out_stall <= 1'b1;
      long_hold--;
    end else begin
      if (pat_left == 0) begin
        pat_mode = $urandom_range(0, 3);
        pat_left = $urandom_range(10, 80);
      end
      pat_left--;
      case (pat_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= ((pat_left % 8) < 5);
      endcase
    end
  end

  always @(posedge clk) begin : check_exit_words
    exit_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (exits_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("tb: unexpected exit word val=%h str=%b emp=%b ovf=%b dz=%b",
                   out_top_value, out_top_is_string, out_stack_empty,
                   out_overflow_seen, out_div_zero_seen);
      end else begin
        want = exits_due.pop_front();
        if (out_top_value !== want.top_value || out_top_is_string !== want.top_is_string ||
            out_stack_empty !== want.stack_empty ||
            out_overflow_seen !== want.overflow_seen ||
            out_div_zero_seen !== want.div_zero_seen) begin
          errors++;
          if (errors <= 10)
            $display("tb: exit word mismatch exp val=%h str=%b emp=%b ovf=%b dz=%b %s",
                     want.top_value, want.top_is_string, want.stack_empty,
                     want.overflow_seen, want.div_zero_seen,
                     $sformatf("got val=%h str=%b emp=%b ovf=%b dz=%b",
                               out_top_value, out_top_is_string, out_stack_empty,
                               out_overflow_seen, out_div_zero_seen));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_op       = sm_alu_pkg::OP_SKIP;
    in_imm      = '0;
    out_stall   = 1'b0;
    depth       = 0;
    ovf_pending = 1'b0;
    dz_pending  = 1'b0;
    errors      = 0;
    burst_left  = 0;
    long_hold   = 0;
    pat_left    = 0;
    pat_mode    = 0;
    idle_cycles = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_full_stack();
    test_backpressure();
    test_random_programs();

    in_valid <= 1'b0;
    while (exits_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

@@ stack_machine_int_alu_core.f @@
rtl/sm_alu_pkg.sv
rtl/sm_alu_ram.sv
rtl/sm_alu_div.sv
rtl/sm_alu_datapath.sv
rtl/sm_alu_ctrl.sv
rtl/stack_machine_int_alu_core.sv
rtl/sm_alu_checker.sv
dv/stack_machine_int_alu_core_test.sv
